// File: rtl/pct_pkg.sv
package pct_pkg;

    // request kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_SET   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // request payload
    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        client_id;
        logic signed [15:0] period;
    } t_req;

    // response payload
    typedef struct packed {
        logic        fired;
        logic [15:0] fired_id;
        logic        accepted;
        logic [14:0] period_value;
        logic        last;
    } t_rsp;

    // which closing response the datapath builds
    typedef enum logic [1:0] {
        RSP_PLAIN,
        RSP_SET,
        RSP_QUERY,
        RSP_TICK_END
    } t_rsp_sel;

    // controller to datapath
    typedef struct packed {
        logic     in_ready;
        logic     load_req;
        logic     rd_scan;
        logic     rd_next;
        logic     tick_update;
        logic     mark_found;
        logic     idx_inc;
        logic     wr_update;
        logic     wr_append;
        logic     wr_shift;
        logic     cnt_dec;
        logic     emit;
        t_rsp_sel rsp_sel;
        logic     set_ok;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic       in_valid;
        logic [1:0] kind;
        logic       per_zero;
        logic       per_neg;
        logic       idx_at_end;
        logic       shift_end;
        logic       id_match;
        logic       fire;
        logic       pend_valid;
        logic       out_free;
        logic       found;
        logic       full;
    } t_dp_status;

endpackage

// File: rtl/pct_stream_if.sv
interface pct_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/pct_ctrl.sv
module pct_ctrl
    import pct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE       = 7'b0000001,
        S_SCAN_RD    = 7'b0000010,
        S_SCAN_EV    = 7'b0000100,
        S_FINISH     = 7'b0001000,
        S_SHIFT_RD   = 7'b0010000,
        S_SHIFT_WR   = 7'b0100000,
        S_SHIFT_DONE = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_dp_cmd cmd;

    // next state and command decode
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                cmd.in_ready = 1'b1;
                if (i_status.in_valid) begin
                    cmd.load_req = 1'b1;
                    n_state      = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_status.idx_at_end) begin
                    n_state = S_FINISH;
                end else begin
                    cmd.rd_scan = 1'b1;
                    n_state     = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                case (i_status.kind)
                    KIND_TICK: begin
                        // a second expiry needs room to push the held one out
                        if (!(i_status.fire && i_status.pend_valid && !i_status.out_free)) begin
                            cmd.tick_update = 1'b1;
                            cmd.idx_inc     = 1'b1;
                            n_state         = S_SCAN_RD;
                        end
                    end
                    KIND_SET, KIND_QUERY: begin
                        if (i_status.id_match) begin
                            cmd.mark_found = 1'b1;
                            n_state        = S_FINISH;
                        end else begin
                            cmd.idx_inc = 1'b1;
                            n_state     = S_SCAN_RD;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    n_state  = S_IDLE;
                    cmd.emit = 1'b1;
                    case (i_status.kind)
                        KIND_TICK: begin
                            cmd.rsp_sel = RSP_TICK_END;
                        end
                        KIND_QUERY: begin
                            cmd.rsp_sel = RSP_QUERY;
                        end
                        KIND_SET: begin
                            cmd.rsp_sel = RSP_SET;
                            if (i_status.per_zero) begin
                                if (i_status.found) begin
                                    // removal: close the gap first
                                    cmd.emit = 1'b0;
                                    n_state  = S_SHIFT_RD;
                                end
                            end else if (i_status.found) begin
                                if (!i_status.per_neg) begin
                                    cmd.wr_update = 1'b1;
                                    cmd.set_ok    = 1'b1;
                                end
                            end else if (!i_status.full) begin
                                cmd.wr_append = 1'b1;
                                cmd.set_ok    = 1'b1;
                            end
                        end
                        default: begin
                            cmd.rsp_sel = RSP_PLAIN;
                        end
                    endcase
                end
            end
            S_SHIFT_RD: begin
                if (i_status.shift_end) begin
                    n_state = S_SHIFT_DONE;
                end else begin
                    cmd.rd_next = 1'b1;
                    n_state     = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                n_state      = S_SHIFT_RD;
            end
            S_SHIFT_DONE: begin
                if (i_status.out_free) begin
                    cmd.cnt_dec = 1'b1;
                    cmd.emit    = 1'b1;
                    cmd.rsp_sel = RSP_SET;
                    cmd.set_ok  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = cmd;

`ifndef NO_ASSERTIONS
    // table shifting only happens for a removal of an entry that was found
    a_shift_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT_WR) |-> (i_status.found && i_status.per_zero))
        else $error("shift without a found entry");

    // an entry is only evaluated after its read was issued, or while its evaluation waits
    a_eval_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_EV) |-> ($past(o_cmd.rd_scan) || $past(r_state == S_SCAN_EV)))
        else $error("evaluation without a preceding read");

    // a new request is never taken while a table walk is running
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_req |-> (r_state == S_IDLE))
        else $error("request taken while busy");
`endif

endmodule

// File: rtl/pct_datapath.sv
module pct_datapath
    import pct_pkg::*;
#(
    parameter int MAX_ENTRIES = 64,
    parameter int ID_WIDTH    = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pct_stream_if.sink        i_req,
    pct_stream_if.source      o_rsp,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef struct packed {
        logic [ID_WIDTH-1:0] id;
        logic [14:0]         period;
        logic [15:0]         countdown;
    } t_entry;

    // table storage
    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rd_data;

    // control registers
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_idx;
    logic                r_found;
    logic                r_pend_valid;
    logic                r_out_valid;

    // payload registers
    t_req                r_req;
    logic [ID_WIDTH-1:0] r_pend_id;
    t_rsp                r_out;

    logic [CNT_W-1:0]    idx_next;
    logic [ID_WIDTH-1:0] req_id;
    logic [14:0]         set_per;
    logic [15:0]         cd_dec;
    logic                fire;
    logic                out_free;
    logic                out_load;
    logic                mem_we;
    logic [IDX_W-1:0]    wr_addr;
    t_entry              wr_data;
    logic                mem_re;
    logic [IDX_W-1:0]    rd_addr;
    t_rsp                n_out;

    assign idx_next = r_idx + CNT_W'(1);
    assign req_id   = ID_WIDTH'(r_req.client_id);
    assign set_per  = r_req.period[15] ? 15'd1 : r_req.period[14:0];

    // countdown step for the entry under evaluation
    assign cd_dec = r_rd_data.countdown - 16'd1;
    assign fire   = cd_dec[15] || (cd_dec == 16'd0);

    assign out_free = !r_out_valid || o_rsp.ready;
    assign out_load = i_cmd.emit || (i_cmd.tick_update && fire && r_pend_valid);

    // write port select
    always_comb begin
        mem_we  = 1'b0;
        wr_addr = r_idx[IDX_W-1:0];
        wr_data = r_rd_data;
        if (i_cmd.tick_update) begin
            mem_we            = 1'b1;
            wr_data.countdown = fire ? {1'b0, r_rd_data.period} : cd_dec;
        end else if (i_cmd.wr_update) begin
            mem_we  = 1'b1;
            wr_data = '{id: req_id, period: set_per, countdown: {1'b0, set_per}};
        end else if (i_cmd.wr_append) begin
            mem_we  = 1'b1;
            wr_addr = r_count[IDX_W-1:0];
            wr_data = '{id: req_id, period: set_per, countdown: {1'b0, set_per}};
        end else if (i_cmd.wr_shift) begin
            mem_we = 1'b1;
        end
    end

    // read port select
    assign mem_re  = i_cmd.rd_scan || i_cmd.rd_next;
    assign rd_addr = i_cmd.rd_next ? idx_next[IDX_W-1:0] : r_idx[IDX_W-1:0];

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // response build
    always_comb begin
        n_out = '0;
        if (i_cmd.emit) begin
            n_out.last = 1'b1;
            case (i_cmd.rsp_sel)
                RSP_SET: begin
                    n_out.accepted = i_cmd.set_ok;
                end
                RSP_QUERY: begin
                    n_out.period_value = r_found ? r_rd_data.period : 15'd0;
                end
                RSP_TICK_END: begin
                    n_out.fired    = r_pend_valid;
                    n_out.fired_id = r_pend_valid ? 16'(r_pend_id) : 16'd0;
                end
                default: begin
                    n_out.last = 1'b1;
                end
            endcase
        end else begin
            // earlier expiry pushed out by a newer one
            n_out.fired    = 1'b1;
            n_out.fired_id = 16'(r_pend_id);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_idx        <= '0;
            r_found      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load_req) begin
                r_idx        <= '0;
                r_found      <= 1'b0;
                r_pend_valid <= 1'b0;
            end else begin
                if (i_cmd.idx_inc) begin
                    r_idx <= idx_next;
                end
                if (i_cmd.mark_found) begin
                    r_found <= 1'b1;
                end
                if (i_cmd.tick_update && fire) begin
                    r_pend_valid <= 1'b1;
                end
            end
            if (i_cmd.wr_append) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req.payload;
        end
        if (i_cmd.tick_update && fire) begin
            r_pend_id <= r_rd_data.id;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign i_req.ready   = i_cmd.in_ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // status to the controller
    always_comb begin
        o_status            = '0;
        o_status.in_valid   = i_req.valid;
        o_status.kind       = r_req.kind;
        o_status.per_zero   = (r_req.period == 16'sd0);
        o_status.per_neg    = r_req.period[15];
        o_status.idx_at_end = (r_idx == r_count);
        o_status.shift_end  = (idx_next >= r_count);
        o_status.id_match   = (r_rd_data.id == req_id);
        o_status.fire       = fire;
        o_status.pend_valid = r_pend_valid;
        o_status.out_free   = out_free;
        o_status.found      = r_found;
        o_status.full       = (r_count == CNT_W'(MAX_ENTRIES));
    end

`ifndef NO_ASSERTIONS
    // the fill count stays within the table
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    // the output register is never overwritten while a response waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("response overwritten");

    // appends never land in a full table
    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_append |-> (r_count < CNT_W'(MAX_ENTRIES)))
        else $error("append into full table");

    // scan reads stay below the fill count
    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_scan |-> (r_idx < r_count))
        else $error("read beyond live entries");
`endif

endmodule

// File: rtl/periodic_callback_timer_table.sv
// Periodic timer table: an ordered list of up to MAX_ENTRIES timers, one per client id.
// Requests enter on i_req (valid/ready); a transaction happens when both are high.
// Responses leave on o_rsp through a single output register; the last response of
// a request carries last = 1.
// A set or query walks the table from the front, one memory read and then one compare
// per entry, stopping at the match, and then answers. A removal first moves every
// later entry down one place, one read and one write per moved entry, then answers.
// A tick visits every entry, reads it and writes back its countdown, and gives one
// response per expired timer in table order (or one response with fired = 0).
// The walk runs over one table memory with a registered read.
// One request is handled at a time; i_req.ready is high only between requests.
// When o_rsp stalls the walk pauses on the next expiry or the final response
// and resumes once the output register is taken; nothing is dropped.
// Synchronous reset empties the table (fill count zero) and clears the output;
// the table memory itself is not cleared.
module periodic_callback_timer_table
    import pct_pkg::*;
#(
    parameter int MAX_ENTRIES = 64,
    parameter int ID_WIDTH    = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pct_stream_if.sink   i_req,
    pct_stream_if.source o_rsp
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencer
    pct_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // table memory and response path
    pct_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ID_WIDTH    (ID_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .o_rsp    (o_rsp),
        .i_cmd    (cmd),
        .o_status (status)
    );

endmodule
